// ----- hdl/atl_pkg.sv -----
// Package for the adaptive time-step limiter: widths, reset values, codes.
// No dependencies.
package atl_pkg;
    localparam int COMP_WIDTH_DEF = 16;
    localparam int STEP_WIDTH_DEF = 32;
    localparam int REG_IDX_W      = 2;
    localparam logic [31:0] SPEED_BOUND_RST  = 32'd65536;
    localparam logic [31:0] ENERGY_BOUND_RST = 32'd65536;
    localparam logic [15:0] GROWTH_RST       = 16'd256;
    localparam logic [31:0] INIT_STEP_RST    = 32'd65536;

    typedef enum logic [1:0] {
        REG_SPEED_BOUND  = 2'd0,
        REG_ENERGY_BOUND = 2'd1,
        REG_GROWTH       = 2'd2,
        REG_INIT_STEP    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        LIM_GROWTH = 2'd0,
        LIM_SPEED  = 2'd1,
        LIM_ENERGY = 2'd2
    } t_limit;

    // front-to-back queue entry: maxima snapshot at end of pass
    typedef struct packed {
        logic [31:0] max_vs;
        logic [63:0] max_vf;
    } t_pass;
endpackage

// ----- hdl/atl_if.sv -----
// Valid/ready channel interfaces for the limiter: particle in, step out, config.
// No dependencies.
interface atl_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] vel_z;
    logic [15:0] frc_x;
    logic [15:0] frc_y;
    logic [15:0] frc_z;
    logic        last_particle;
    modport source (output valid, vel_x, vel_y, vel_z, frc_x, frc_y, frc_z,
                    last_particle, input ready);
    modport sink   (input valid, vel_x, vel_y, vel_z, frc_x, frc_y, frc_z,
                    last_particle, output ready);
endinterface

interface atl_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_step;
    logic [1:0]  limited_by;
    modport source (output valid, new_step, limited_by, input ready);
    modport sink   (input valid, new_step, limited_by, output ready);
endinterface

interface atl_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/atl_front.sv -----
// Front end: squares components, tracks both maxima, hands pass snapshot on.
// Depends on atl_pkg.
module atl_front
    import atl_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_vx, i_vy, i_vz, i_fx, i_fy, i_fz,
    input  logic        i_last,
    output logic        o_q_valid,
    input  logic        i_q_ready,
    output t_pass       o_q_pass
);
    localparam int SQ_W = 2 * COMP_WIDTH;

    // stage 1 registers
    logic              r_s1_v, r_s1_last;
    logic [SQ_W+1:0]   r_s1_vs, r_s1_fs;
    // stage 2
    logic              r_s2_v, r_s2_last;
    logic [31:0]       r_s2_vs;
    logic [63:0]       r_s2_vf;
    logic [31:0]       r_max_vs;
    logic [63:0]       r_max_vf;
    logic              r_q_v;
    t_pass             r_q;
    logic [31:0]       n_max_vs;
    logic [63:0]       n_max_vf;

    function automatic logic [SQ_W-1:0] f_sq(input logic [15:0] raw);
        logic [COMP_WIDTH-1:0] x;
        logic [COMP_WIDTH:0]   m;
        logic [2*COMP_WIDTH+1:0] p;
        x = raw[COMP_WIDTH-1:0];
        m = x[COMP_WIDTH-1] ? ({1'b1, {COMP_WIDTH{1'b0}}} - {1'b0, x}) : {1'b0, x};
        p = m * m;
        return p[SQ_W-1:0] | {SQ_W{p[SQ_W]}};
    endfunction

    // stalls only when a last item would meet a full queue entry
    logic s2_block;
    assign s2_block = r_s2_v && r_s2_last && r_q_v && !i_q_ready;
    assign o_ready  = !s2_block;

    always_comb begin
        n_max_vs = (r_s2_vs > r_max_vs) ? r_s2_vs : r_max_vs;
        n_max_vf = (r_s2_vf > r_max_vf) ? r_s2_vf : r_max_vf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_q_v    <= 1'b0;
            r_max_vs <= '0;
            r_max_vf <= '0;
        end else begin
            if (r_q_v && i_q_ready) r_q_v <= 1'b0;
            if (!s2_block) begin
                r_s1_v    <= i_valid;
                r_s1_last <= i_last;
                r_s1_vs   <= (SQ_W+2)'(f_sq(i_vx)) + (SQ_W+2)'(f_sq(i_vy))
                             + (SQ_W+2)'(f_sq(i_vz));
                r_s1_fs   <= (SQ_W+2)'(f_sq(i_fx)) + (SQ_W+2)'(f_sq(i_fy))
                             + (SQ_W+2)'(f_sq(i_fz));
                r_s2_v    <= r_s1_v;
                r_s2_last <= r_s1_last;
                r_s2_vs   <= 32'(r_s1_vs);
                r_s2_vf   <= 64'(r_s1_vs) * 64'(r_s1_fs);
                if (r_s2_v) begin
                    if (r_s2_last) begin
                        r_q_v        <= 1'b1;
                        r_q.max_vs   <= n_max_vs;
                        r_q.max_vf   <= n_max_vf;
                        r_max_vs     <= '0;
                        r_max_vf     <= '0;
                    end else begin
                        r_max_vs <= n_max_vs;
                        r_max_vf <= n_max_vf;
                    end
                end
            end
        end
    end

    assign o_q_valid = r_q_v;
    assign o_q_pass  = r_q;
endmodule

// ----- hdl/atl_back.sv -----
// Back end: root and divide per pass, picks the smallest candidate step.
// Depends on atl_pkg.
module atl_back
    import atl_pkg::*;
#(
    parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_pass       i_q_pass,
    input  logic [31:0] i_speed_bound,
    input  logic [31:0] i_energy_bound,
    input  logic [15:0] i_growth,
    input  logic [31:0] i_init_step,
    input  logic        i_load_step,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_step,
    output logic [1:0]  o_limit
);
    localparam logic [63:0] STEP_MAX = 64'((65'd1 << STEP_WIDTH) - 65'd1);

    typedef enum logic [2:0] {
        S_IDLE, S_GROW, S_SQRT, S_DIV, S_PICK, S_OUT
    } t_state;

    t_state       r_state;
    logic         r_phase;      // 0 speed bound, 1 energy bound
    logic [31:0]  r_cur;
    logic [63:0]  r_best;
    logic [1:0]   r_which;
    logic [31:0]  r_mvs;
    logic [63:0]  r_mvf;
    logic [63:0]  r_gprod;
    // root unit
    logic [63:0]  r_rv, r_rr, r_rbit;
    // divide unit
    logic [47:0]  r_num;
    logic [47:0]  r_quo;
    logic [32:0]  r_rem;
    logic [5:0]   r_cnt;
    logic         r_out_v;
    logic [31:0]  r_out_step;
    logic [1:0]   r_out_lim;

    logic [63:0]  sum_rb;
    logic [32:0]  rem_sh;
    logic [63:0]  cand;
    assign sum_rb = r_rr + r_rbit;
    assign rem_sh = {r_rem[31:0], r_num[47]};
    assign cand   = (64'(r_quo) > STEP_MAX) ? STEP_MAX : 64'(r_quo);

    assign o_q_ready = (r_state == S_IDLE) && !r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_cur   <= INIT_STEP_RST;
        end else begin
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            if (i_load_step) r_cur <= i_init_step;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && !r_out_v) begin
                        r_mvs   <= i_q_pass.max_vs;
                        r_mvf   <= i_q_pass.max_vf;
                        r_gprod <= 64'(i_growth) * 64'(r_cur);
                        r_state <= S_GROW;
                    end
                end
                S_GROW: begin
                    r_best  <= ((r_gprod >> 8) > STEP_MAX) ? STEP_MAX : (r_gprod >> 8);
                    r_which <= LIM_GROWTH;
                    r_phase <= 1'b0;
                    r_rr    <= '0;
                    r_rbit  <= 64'd1 << 62;
                    if (r_mvs != 0) begin
                        r_rv    <= {16'd0, r_mvs, 16'd0};
                        r_state <= S_SQRT;
                    end else if (r_mvf != 0) begin
                        r_rv    <= r_mvf;
                        r_phase <= 1'b1;
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SQRT: begin
                    if (r_rbit == 0) begin
                        r_num   <= {r_phase ? i_energy_bound : i_speed_bound, 16'd0};
                        r_rem   <= '0;
                        r_cnt   <= 6'd47;
                        r_state <= S_DIV;
                    end else begin
                        if (r_rv >= sum_rb) begin
                            r_rv <= r_rv - sum_rb;
                            r_rr <= (r_rr >> 1) + r_rbit;
                        end else begin
                            r_rr <= r_rr >> 1;
                        end
                        r_rbit <= r_rbit >> 2;
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[46:0], 1'b0};
                    if (64'(rem_sh) >= r_rr) begin
                        r_rem <= 33'(64'(rem_sh) - r_rr);
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    if (r_cnt == 0) r_state <= S_PICK;
                    r_cnt <= r_cnt - 6'd1;
                end
                S_PICK: begin
                    if (cand <= r_best) begin
                        r_best  <= cand;
                        r_which <= r_phase ? LIM_ENERGY : LIM_SPEED;
                    end
                    if (!r_phase && r_mvf != 0) begin
                        r_phase <= 1'b1;
                        r_rv    <= r_mvf;
                        r_rr    <= '0;
                        r_rbit  <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_out_v    <= 1'b1;
                    r_out_step <= r_best[31:0];
                    r_out_lim  <= r_which;
                    r_cur      <= r_best[31:0];
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_step  = r_out_step;
    assign o_limit = r_out_lim;
endmodule

// ----- hdl/adaptive_timestep_limiter.sv -----
// Top level of the adaptive time-step limiter: config registers, front, back.
// Depends on atl_pkg, atl_if, atl_front, atl_back.
// Particles are taken one per cycle; the front squares and tracks maxima in a
// two-stage pipeline. A last particle hands the maxima to the back end, which
// runs a radix-4 root and a restoring divide per nonzero maximum. Particles
// of the next pass keep streaming meanwhile; input stalls only if a second pass
// ends before the back end has taken the previous one.
module adaptive_timestep_limiter
    import atl_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    atl_in_if.sink   in_ch,
    atl_out_if.source out_ch,
    atl_cfg_if.sink  cfg_ch
);
    localparam logic [31:0] STEP_MAX32 = 32'((64'd1 << STEP_WIDTH) - 64'd1);

    logic [31:0] r_speed_bound, r_energy_bound, r_init_step;
    logic [15:0] r_growth;
    logic        r_load;
    logic        cfg_wr;
    logic        q_valid, q_ready;
    t_pass       q_pass;

    assign cfg_ch.ready = 1'b1;
    assign cfg_wr = cfg_ch.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_bound  <= SPEED_BOUND_RST;
            r_energy_bound <= ENERGY_BOUND_RST;
            r_growth       <= GROWTH_RST;
            r_init_step    <= INIT_STEP_RST;
            r_load         <= 1'b0;
        end else begin
            r_load <= 1'b0;
            if (cfg_wr) begin
                case (cfg_ch.index)
                    8'(REG_SPEED_BOUND):  r_speed_bound  <= cfg_ch.data;
                    8'(REG_ENERGY_BOUND): r_energy_bound <= cfg_ch.data;
                    8'(REG_GROWTH):       r_growth       <= cfg_ch.data[15:0];
                    8'(REG_INIT_STEP): begin
                        r_init_step <= (cfg_ch.data > STEP_MAX32) ? STEP_MAX32
                                                                  : cfg_ch.data;
                        r_load      <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    atl_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_ch.valid),
        .o_ready   (in_ch.ready),
        .i_vx      (in_ch.vel_x),
        .i_vy      (in_ch.vel_y),
        .i_vz      (in_ch.vel_z),
        .i_fx      (in_ch.frc_x),
        .i_fy      (in_ch.frc_y),
        .i_fz      (in_ch.frc_z),
        .i_last    (in_ch.last_particle),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_pass  (q_pass)
    );

    atl_back #(.STEP_WIDTH(STEP_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_ready      (q_ready),
        .i_q_pass       (q_pass),
        .i_speed_bound  (r_speed_bound),
        .i_energy_bound (r_energy_bound),
        .i_growth       (r_growth),
        .i_init_step    (r_init_step),
        .i_load_step    (r_load),
        .o_valid        (out_ch.valid),
        .i_ready        (out_ch.ready),
        .o_step         (out_ch.new_step),
        .o_limit        (out_ch.limited_by)
    );
endmodule

// ----- tb/tb_top.sv -----
// Testbench for adaptive_timestep_limiter: drives particles and config writes,
// checks each new step against an in-bench predictor of the limiter or, for the
// directed rows, against the table's step. Depends on atl_pkg, atl_if, the RTL.
module tb_top;
    import atl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 220;
    localparam int          RANDOM_ITEMS   = 1250;
    localparam logic [7:0]  IDX_FIRST_BAD  = 8'd4;

    typedef struct {
        logic [15:0] vel [3];
        logic [15:0] frc [3];
        logic        last;
    } t_particle;

    typedef struct {
        logic [31:0] step;
        t_limit      lim;
    } t_step_res;

    typedef struct {
        logic [15:0] vel [3];
        logic [15:0] frc [3];
        logic        last;
        bit          typed;
        logic [31:0] step;
        t_limit      lim;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    atl_in_if  in_ch ();
    atl_out_if out_ch ();
    atl_cfg_if cfg_ch ();

    adaptive_timestep_limiter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    // limiter state mirror
    logic [31:0] speed_bound_q;
    logic [31:0] energy_bound_q;
    logic [15:0] growth_q;
    logic [31:0] step_q;
    logic [63:0] max_vs_q;
    logic [63:0] max_vf_q;

    t_step_res   step_queue[$];
    int          mismatches;
    int          items_sent;
    int          steps_seen;
    int          cfg_writes;
    int          idle_cycles;
    bit          calm;
    int          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] comp_sq(input logic [15:0] c);
        logic [63:0] mag;
        mag = c[15] ? (64'h10000 - 64'(c)) : 64'(c);
        return mag * mag;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        rem = v;
        r   = '0;
        b   = 64'h1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - r - b;
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] clip_step(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    task automatic limit_step(input t_particle p, output bit emits, output t_step_res res);
        logic [63:0] vs;
        logic [63:0] fs;
        logic [63:0] vf;
        logic [63:0] best;
        logic [63:0] cand;
        t_limit      which;
        vs = comp_sq(p.vel[0]) + comp_sq(p.vel[1]) + comp_sq(p.vel[2]);
        fs = comp_sq(p.frc[0]) + comp_sq(p.frc[1]) + comp_sq(p.frc[2]);
        vf = vs * fs;
        if (vs > max_vs_q) max_vs_q = vs;
        if (vf > max_vf_q) max_vf_q = vf;
        emits = p.last;
        if (!p.last) return;
        which = LIM_GROWTH;
        best  = clip_step((64'(growth_q) * 64'(step_q)) >> 8);
        if (max_vs_q != 0) begin
            cand = clip_step((64'(speed_bound_q) << 16) / root64(max_vs_q << 16));
            if (cand <= best) begin
                best  = cand;
                which = LIM_SPEED;
            end
        end
        if (max_vf_q != 0) begin
            cand = clip_step((64'(energy_bound_q) << 16) / root64(max_vf_q));
            if (cand <= best) begin
                best  = cand;
                which = LIM_ENERGY;
            end
        end
        step_q   = best[31:0];
        max_vs_q = '0;
        max_vf_q = '0;
        res.step = best[31:0];
        res.lim  = which;
    endtask

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    task automatic send_particle(input t_particle p, input bit typed,
                                 input t_step_res typed_res);
        bit        emits;
        t_step_res res;
        idle_gap();
        in_ch.valid         = 1'b1;
        in_ch.vel_x         = p.vel[0];
        in_ch.vel_y         = p.vel[1];
        in_ch.vel_z         = p.vel[2];
        in_ch.frc_x         = p.frc[0];
        in_ch.frc_y         = p.frc[1];
        in_ch.frc_z         = p.frc[2];
        in_ch.last_particle = p.last;
        do @(posedge i_clk); while (!in_ch.ready);
        limit_step(p, emits, res);
        if (emits) step_queue.push_back(typed ? typed_res : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        in_ch.valid  = 1'b0;
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            8'(REG_SPEED_BOUND):  speed_bound_q  = data;
            8'(REG_ENERGY_BOUND): energy_bound_q = data;
            8'(REG_GROWTH):       growth_q       = data[15:0];
            8'(REG_INIT_STEP):    step_q         = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // hold until every expected step has come, then let the back end settle
    task automatic drain();
        in_ch.valid = 1'b0;
        while (step_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return 16'($urandom_range(0, 64)) * ($urandom_range(0, 1) ? 16'hFFFF : 16'h1);
            4:       return 16'($signed($urandom_range(0, 4096)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pass(input int len);
        t_particle p;
        t_step_res dummy;
        for (int k = 0; k < len; k++) begin
            for (int j = 0; j < 3; j++) begin
                p.vel[j] = rand_comp();
                p.frc[j] = rand_comp();
            end
            p.last = (k == len - 1);
            send_particle(p, 1'b0, dummy);
        end
    endtask

    function automatic logic [31:0] rand_reg_val();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(1, 32'h0004_0000));
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, plus one long hold on request
    initial begin
        int stall_left;
        int hold_cnt;
        stall_left   = 0;
        hold_cnt     = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                out_ch.ready = 1'b0;
                hold_cnt--;
            end else if (calm) begin
                out_ch.ready = 1'b1;
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 7) - 1;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_step_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            steps_seen++;
            if (step_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("step transfer with none expected: step=%h lim=%0d",
                             out_ch.new_step, out_ch.limited_by);
            end else begin
                want = step_queue.pop_front();
                if (out_ch.new_step !== want.step || out_ch.limited_by !== want.lim) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("step mismatch: exp step=%h lim=%0d got step=%h lim=%0d",
                                 want.step, want.lim, out_ch.new_step, out_ch.limited_by);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_dir_row  rows[$];
        t_dir_row  r;
        t_particle p;
        t_step_res tr;
        int        n;

        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.vel_x   = '0;
        in_ch.vel_y   = '0;
        in_ch.vel_z   = '0;
        in_ch.frc_x   = '0;
        in_ch.frc_y   = '0;
        in_ch.frc_z   = '0;
        in_ch.last_particle = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        calm          = 1'b0;
        hold_req      = 0;
        mismatches    = 0;
        items_sent    = 0;
        steps_seen    = 0;
        cfg_writes    = 0;
        idle_cycles   = 0;
        speed_bound_q  = SPEED_BOUND_RST;
        energy_bound_q = ENERGY_BOUND_RST;
        growth_q       = GROWTH_RST;
        step_q         = INIT_STEP_RST;
        max_vs_q       = '0;
        max_vf_q       = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // vel x3, frc x3, last, typed, step, limit
        rows = '{
            '{'{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}, 1'b1, 1'b1,
              32'd65536, LIM_GROWTH},
            '{'{16'h8000, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}, 1'b1, 1'b1,
              32'd512, LIM_SPEED},
            '{'{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}, 1'b1, 1'b1,
              32'd512, LIM_GROWTH},
            '{'{16'h8000, 16'h0, 16'h0}, '{16'h8000, 16'h0, 16'h0}, 1'b1, 1'b1,
              32'd4, LIM_ENERGY},
            '{'{16'h7FFF, 16'h7FFF, 16'h7FFF}, '{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0,
              1'b0, 32'd0, LIM_GROWTH},
            '{'{16'h8000, 16'h8000, 16'h8000}, '{16'h8000, 16'h8000, 16'h8000}, 1'b0,
              1'b0, 32'd0, LIM_GROWTH},
            '{'{16'h0001, 16'hFFFF, 16'h0}, '{16'h0, 16'h0, 16'h0}, 1'b1, 1'b0,
              32'd0, LIM_GROWTH},
            '{'{16'h0100, 16'h0, 16'h0}, '{16'h0, 16'h0100, 16'h0}, 1'b0, 1'b0,
              32'd0, LIM_GROWTH},
            '{'{16'h0, 16'hFF00, 16'h0}, '{16'h0, 16'h0, 16'h0}, 1'b1, 1'b0,
              32'd0, LIM_GROWTH},
            '{'{16'h0, 16'h0, 16'h0001}, '{16'h0001, 16'h0, 16'h0}, 1'b1, 1'b0,
              32'd0, LIM_GROWTH},
            '{'{16'h5555, 16'hAAAA, 16'h1234}, '{16'hAAAA, 16'h5555, 16'hEDCB}, 1'b1,
              1'b0, 32'd0, LIM_GROWTH},
            '{'{16'h0, 16'h0, 16'h0}, '{16'h7FFF, 16'h8000, 16'h7FFF}, 1'b1, 1'b0,
              32'd0, LIM_GROWTH}
        };
        foreach (rows[i]) begin
            r      = rows[i];
            p.vel  = r.vel;
            p.frc  = r.frc;
            p.last = r.last;
            tr.step = r.step;
            tr.lim  = r.lim;
            send_particle(p, r.typed, tr);
        end
        drain();

        // register extremes, one or two passes after each group of writes, then bad indexes
        write_reg(8'(REG_SPEED_BOUND), 32'h0);
        send_pass(2);
        send_pass(1);
        drain();
        write_reg(8'(REG_SPEED_BOUND), 32'hFFFF_FFFF);
        write_reg(8'(REG_ENERGY_BOUND), 32'h0);
        send_pass(3);
        drain();
        write_reg(8'(REG_ENERGY_BOUND), 32'hFFFF_FFFF);
        write_reg(8'(REG_GROWTH), 32'h0000_FFFF);
        write_reg(8'(REG_INIT_STEP), 32'hFFFF_FFFF);
        send_pass(1);
        send_pass(2);
        drain();
        write_reg(8'(REG_GROWTH), 32'h0);
        write_reg(8'(REG_INIT_STEP), 32'h0);
        send_pass(2);
        drain();
        write_reg(IDX_FIRST_BAD, 32'hDEAD_BEEF);
        write_reg(8'hFF, 32'h1234_5678);
        write_reg(8'(REG_GROWTH), 32'd300);
        write_reg(8'(REG_INIT_STEP), 32'd65536);
        write_reg(8'(REG_SPEED_BOUND), 32'd65536);
        write_reg(8'(REG_ENERGY_BOUND), 32'd65536);

        // long receiver hold while short passes pile up
        hold_req = 400;
        for (int i = 0; i < 12; i++) send_pass($urandom_range(1, 2));
        drain();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (n > RANDOM_ITEMS - 150) calm = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                drain();
                if ($urandom_range(0, 7) == 0)
                    write_reg(8'($urandom_range(4, 255)), $urandom);
                else
                    write_reg(8'($urandom_range(0, 3)), rand_reg_val());
            end
            if ($urandom_range(0, 9) == 0) begin
                send_pass($urandom_range(20, 40));
            end else begin
                send_pass($urandom_range(1, 8));
            end
            n = items_sent;
        end
        drain();

        $display("Sent %0d particles and %0d register writes; checked %0d new steps.",
                 items_sent, cfg_writes, steps_seen);
        $display("Covered register extremes, bad indexes, a long output hold, random passes.");
        if (mismatches == 0 && step_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
